@@ sv/tbs_pkg.sv @@
// Shared types and constants for the triangle barycentric shader.
// Used by every module of the block; has no dependencies of its own.
package tbs_pkg;

  localparam int CoordW = 11;
  localparam int QuotW  = 13;
  localparam int DenW   = 24;
  localparam int RemW   = 25;
  localparam int AddrW  = 17;
  localparam int ChanW  = 5;
  localparam int ColorW = 15;
  localparam int IndexW = 3;

  // Configuration register indexes.
  localparam logic [IndexW-1:0] RegAX = 3'd0;
  localparam logic [IndexW-1:0] RegAY = 3'd1;
  localparam logic [IndexW-1:0] RegBX = 3'd2;
  localparam logic [IndexW-1:0] RegBY = 3'd3;
  localparam logic [IndexW-1:0] RegCX = 3'd4;
  localparam logic [IndexW-1:0] RegCY = 3'd5;

  // Q12 one, as a 15-bit signed constant.
  localparam logic signed [14:0] WeightOne = 15'sd4096;

  // Item carried along the divider chain: both weights are divided at once.
  typedef struct packed {
    logic              kill;
    logic [AddrW-1:0]  addr;
    logic [DenW-1:0]   den;
    logic [RemW-1:0]   rem_b;
    logic [RemW-1:0]   rem_g;
    logic              neg_b;
    logic              neg_g;
    logic [QuotW-1:0]  q_b;
    logic [QuotW-1:0]  q_g;
  } div_t;

endpackage

@@ sv/tbs_setup.sv @@
// Front end of the shader: edge vectors, cross-product terms and divider setup.
// Two registered stages; depends on tbs_pkg.
module tbs_setup #(
  parameter int FRAME_COLUMNS = 320,
  parameter int FRAME_ROWS    = 240
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [8:0]               pixel_x,
  input  logic [7:0]               pixel_y,
  input  logic signed [10:0]       ax,
  input  logic signed [10:0]       ay,
  input  logic signed [10:0]       bx,
  input  logic signed [10:0]       by,
  input  logic signed [10:0]       cx,
  input  logic signed [10:0]       cy,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tbs_pkg::div_t            out_item
);

  logic signed [11:0] abx, aby, acx, acy, apx, apy;
  logic s1_valid, s1_ready, s2_ready;
  logic signed [23:0] p_a1, p_a2, p_b1, p_b2, p_g1, p_g2;
  logic [tbs_pkg::AddrW-1:0] s1_addr;
  logic s1_outside;

  logic signed [24:0] area, cross_b, cross_g;
  logic [24:0] mag_a, mag_b, mag_g;
  logic [tbs_pkg::DenW-1:0] den;
  logic ovf_b, ovf_g;

  assign abx = {bx[10], bx} - {ax[10], ax};
  assign aby = {by[10], by} - {ay[10], ay};
  assign acx = {cx[10], cx} - {ax[10], ax};
  assign acy = {cy[10], cy} - {ay[10], ay};
  assign apx = {3'b000, pixel_x} - {ax[10], ax};
  assign apy = {4'b0000, pixel_y} - {ay[10], ay};

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      p_a1       <= abx * acy;
      p_a2       <= aby * acx;
      p_b1       <= apx * acy;
      p_b2       <= apy * acx;
      p_g1       <= abx * apy;
      p_g2       <= aby * apx;
      s1_addr    <= tbs_pkg::AddrW'(32'(pixel_y) * 32'(FRAME_COLUMNS) + 32'(pixel_x));
      s1_outside <= (32'(pixel_x) >= 32'(FRAME_COLUMNS)) ||
                    (32'(pixel_y) >= 32'(FRAME_ROWS));
    end
  end

  assign area    = {p_a1[23], p_a1} - {p_a2[23], p_a2};
  assign cross_b = {p_b1[23], p_b1} - {p_b2[23], p_b2};
  assign cross_g = {p_g1[23], p_g1} - {p_g2[23], p_g2};

  assign mag_a = area[24]    ? 25'(-area)    : 25'(area);
  assign mag_b = cross_b[24] ? 25'(-cross_b) : 25'(cross_b);
  assign mag_g = cross_g[24] ? 25'(-cross_g) : 25'(cross_g);
  assign den   = mag_a[tbs_pkg::DenW-1:0];

  // A quotient of 8192 or more can never give a covered pixel.
  assign ovf_b = mag_b >= {den, 1'b0};
  assign ovf_g = mag_g >= {den, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      out_item.kill  <= (den == '0) || s1_outside || ovf_b || ovf_g;
      out_item.addr  <= s1_addr;
      out_item.den   <= den;
      out_item.rem_b <= mag_b;
      out_item.rem_g <= mag_g;
      out_item.neg_b <= cross_b[24] ^ area[24];
      out_item.neg_g <= cross_g[24] ^ area[24];
      out_item.q_b   <= '0;
      out_item.q_g   <= '0;
    end
  end

endmodule

@@ sv/tbs_div_cell.sv @@
// One cell of the divider chain: one quotient bit for each of the two weights.
// Depends on tbs_pkg.
module tbs_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tbs_pkg::div_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output tbs_pkg::div_t out_item
);

  logic ge_b, ge_g;
  logic [tbs_pkg::RemW-1:0] diff_b, diff_g;
  tbs_pkg::div_t item_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    ge_b   = in_item.rem_b >= {1'b0, in_item.den};
    ge_g   = in_item.rem_g >= {1'b0, in_item.den};
    diff_b = ge_b ? in_item.rem_b - {1'b0, in_item.den} : in_item.rem_b;
    diff_g = ge_g ? in_item.rem_g - {1'b0, in_item.den} : in_item.rem_g;
    item_next       = in_item;
    // The remainder stays below the divisor, so the shift loses nothing.
    item_next.rem_b = {diff_b[tbs_pkg::RemW-2:0], 1'b0};
    item_next.rem_g = {diff_g[tbs_pkg::RemW-2:0], 1'b0};
    item_next.q_b   = {in_item.q_b[tbs_pkg::QuotW-2:0], ge_b};
    item_next.q_g   = {in_item.q_g[tbs_pkg::QuotW-2:0], ge_g};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

@@ sv/tbs_shade.sv @@
// Back end of the shader: signed weights, coverage test and RGB555 color.
// Holds the output register; depends on tbs_pkg.
module tbs_shade (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tbs_pkg::div_t               in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        covered,
  output logic [tbs_pkg::AddrW-1:0]   pixel_address,
  output logic [tbs_pkg::ColorW-1:0]  pixel_color
);

  logic neg_any, hit;
  logic signed [14:0] alpha;
  logic [tbs_pkg::ColorW-1:0] color;

  function automatic logic [tbs_pkg::ChanW-1:0] chan(input logic [12:0] w);
    logic [17:0] t;
    t = {w, 5'b00000} - {5'b00000, w};
    chan = (t[17:12] > 6'd31) ? 5'd31 : t[16:12];
  endfunction

  always_comb begin
    neg_any = (in_item.neg_b && in_item.q_b != '0) || (in_item.neg_g && in_item.q_g != '0);
    alpha   = tbs_pkg::WeightOne - $signed({2'b00, in_item.q_b})
                                 - $signed({2'b00, in_item.q_g});
    hit     = !in_item.kill && !neg_any && !alpha[14];
    color   = hit ? {chan(alpha[12:0]), chan(in_item.q_b), chan(in_item.q_g)} : '0;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      covered       <= hit;
      pixel_address <= in_item.addr;
      pixel_color   <= color;
    end
  end

endmodule

@@ sv/triangle_barycentric_shader_top.sv @@
// Barycentric triangle shader: takes one pixel position per item and returns
// coverage, frame-buffer address and an RGB555 color, one item per clock when
// neither side stalls. The pipe holds two setup stages, a chain of 13
// divider cells that each resolve one quotient bit of both Q12 weights, and
// the output register. Every stage has its own valid bit, so the pipe keeps
// taking items into empty stages while a result waits at the output.
module triangle_barycentric_shader_top #(
  parameter int FRAME_COLUMNS = 320,
  parameter int FRAME_ROWS    = 240
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [tbs_pkg::IndexW-1:0]  cfg_index,
  input  logic [tbs_pkg::CoordW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [8:0]                  pixel_x,
  input  logic [7:0]                  pixel_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        covered,
  output logic [tbs_pkg::AddrW-1:0]   pixel_address,
  output logic [tbs_pkg::ColorW-1:0]  pixel_color
);

  localparam int Cells = tbs_pkg::QuotW;

  logic signed [10:0] vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y;
  logic signed [10:0] vertex_c_x, vertex_c_y;

  logic          chain_valid [0:Cells];
  logic          chain_ready [0:Cells];
  tbs_pkg::div_t chain_item  [0:Cells];

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a_x <= '0;
      vertex_a_y <= '0;
      vertex_b_x <= '0;
      vertex_b_y <= '0;
      vertex_c_x <= '0;
      vertex_c_y <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tbs_pkg::RegAX: vertex_a_x <= cfg_data;
        tbs_pkg::RegAY: vertex_a_y <= cfg_data;
        tbs_pkg::RegBX: vertex_b_x <= cfg_data;
        tbs_pkg::RegBY: vertex_b_y <= cfg_data;
        tbs_pkg::RegCX: vertex_c_x <= cfg_data;
        tbs_pkg::RegCY: vertex_c_y <= cfg_data;
        default: ;
      endcase
    end
  end

  tbs_setup #(
    .FRAME_COLUMNS(FRAME_COLUMNS),
    .FRAME_ROWS   (FRAME_ROWS)
  ) u_setup (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y),
    .ax       (vertex_a_x),
    .ay       (vertex_a_y),
    .bx       (vertex_b_x),
    .by       (vertex_b_y),
    .cx       (vertex_c_x),
    .cy       (vertex_c_y),
    .out_valid(chain_valid[0]),
    .out_ready(chain_ready[0]),
    .out_item (chain_item[0])
  );

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    tbs_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (chain_valid[i]),
      .in_ready (chain_ready[i]),
      .in_item  (chain_item[i]),
      .out_valid(chain_valid[i+1]),
      .out_ready(chain_ready[i+1]),
      .out_item (chain_item[i+1])
    );
  end

  tbs_shade u_shade (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (chain_valid[Cells]),
    .in_ready     (chain_ready[Cells]),
    .in_item      (chain_item[Cells]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .covered      (covered),
    .pixel_address(pixel_address),
    .pixel_color  (pixel_color)
  );

endmodule

@@ sv/tbs_checker.sv @@
// Port-level checks for the triangle barycentric shader, bound to the top level.
// Depends on tbs_pkg and triangle_barycentric_shader_top.
module tbs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        covered,
  input logic [tbs_pkg::AddrW-1:0]   pixel_address,
  input logic [tbs_pkg::ColorW-1:0]  pixel_color
);

  // A stalled result item holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(covered) &&
      $stable(pixel_address) && $stable(pixel_color))
    else $error("stalled result item changed");

  // The weights of a covered pixel sum to one, so some channel is lit.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && covered |-> pixel_color != '0)
    else $error("covered pixel has no color");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !covered |-> pixel_color == '0)
    else $error("uncovered pixel has a color");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item right after reset");

endmodule

bind triangle_barycentric_shader_top tbs_checker u_tbs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .covered      (covered),
  .pixel_address(pixel_address),
  .pixel_color  (pixel_color)
);

@@ bench/tb_triangle_barycentric_shader_top.sv @@
// Testbench for the triangle barycentric shader: drives pixel items under
// several vertex settings and checks coverage, address and color per item.
// Depends on tbs_pkg and triangle_barycentric_shader_top.
`timescale 1ns / 100ps

module tb_triangle_barycentric_shader_top;

  localparam int Cols = 320;
  localparam int Rows = 240;
  localparam int WatchLimit = 2000;

  typedef struct {
    logic                              cov;
    logic [tbs_pkg::AddrW-1:0]         addr;
    logic [tbs_pkg::ColorW-1:0]        color;
  } shade_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [tbs_pkg::IndexW-1:0] cfg_index = '0;
  logic [tbs_pkg::CoordW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [8:0] pixel_x = '0;
  logic [7:0] pixel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic covered;
  logic [tbs_pkg::AddrW-1:0] pixel_address;
  logic [tbs_pkg::ColorW-1:0] pixel_color;

  longint vert[6];
  shade_t shade_queue[$];
  int errors = 0;
  int shaded = 0;
  int hits = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  int sink_hold = 0;

  triangle_barycentric_shader_top #(.FRAME_COLUMNS(Cols), .FRAME_ROWS(Rows)) u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .out_valid(out_valid),
    .out_ready(out_ready), .covered(covered), .pixel_address(pixel_address),
    .pixel_color(pixel_color)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint scale_channel(longint w);
    longint c;
    c = (w * 31) / 4096;
    if (c < 0) c = 0;
    if (c > 31) c = 31;
    return c;
  endfunction

  function automatic shade_t shade_pixel(int px, int py);
    shade_t r;
    longint abx, aby, acx, acy, apx, apy, area, bc, gc, beta, gamma, alpha;
    r.cov = 1'b0;
    r.color = '0;
    r.addr = tbs_pkg::AddrW'(py * Cols + px);
    abx = vert[tbs_pkg::RegBX] - vert[tbs_pkg::RegAX];
    aby = vert[tbs_pkg::RegBY] - vert[tbs_pkg::RegAY];
    acx = vert[tbs_pkg::RegCX] - vert[tbs_pkg::RegAX];
    acy = vert[tbs_pkg::RegCY] - vert[tbs_pkg::RegAY];
    apx = px - vert[tbs_pkg::RegAX];
    apy = py - vert[tbs_pkg::RegAY];
    area = abx * acy - aby * acx;
    if (area != 0 && px < Cols && py < Rows) begin
      bc = apx * acy - apy * acx;
      gc = abx * apy - aby * apx;
      beta = (bc * 4096) / area;
      gamma = (gc * 4096) / area;
      alpha = 4096 - beta - gamma;
      if (alpha >= 0 && beta >= 0 && gamma >= 0) begin
        r.cov = 1'b1;
        r.color = tbs_pkg::ColorW'((scale_channel(alpha) << 10) |
                                   (scale_channel(beta) << 5) | scale_channel(gamma));
      end
    end
    return r;
  endfunction

  // Result side: random stall bursts unless calm is set, checked against the oldest expectation.
  always @(posedge clk) begin
    shade_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (shade_queue.size() == 0) begin
          $display("%0t: unexpected item cov=%0b addr=%0d color=%h", $time,
                   covered, pixel_address, pixel_color);
          errors++;
        end else begin
          want = shade_queue.pop_front();
          shaded++;
          if (want.cov) hits++;
          if (covered !== want.cov) begin
            $display("%0t: covered expected %0b actual %0b", $time, want.cov, covered);
            errors++;
          end
          if (pixel_address !== want.addr) begin
            $display("%0t: pixel_address expected %0d actual %0d", $time, want.addr,
                     pixel_address);
            errors++;
          end
          if (pixel_color !== want.color) begin
            $display("%0t: pixel_color expected %h actual %h", $time, want.color,
                     pixel_color);
            errors++;
          end
        end
      end
      if (calm) begin
        out_ready <= 1'b1;
      end else if (sink_hold != 0) begin
        out_ready <= 1'b0;
        sink_hold <= sink_hold - 1;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        sink_hold <= $urandom_range(0, 7);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("tb_triangle_barycentric_shader_top: errors");
      $finish;
    end
  end

  // The write enable stays high across a run of writes; the caller drops it.
  task automatic write_reg(logic [tbs_pkg::IndexW-1:0] idx, longint value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= tbs_pkg::CoordW'(value);
    @(posedge clk);
    if (idx <= tbs_pkg::RegCY) vert[idx] = longint'($signed(tbs_pkg::CoordW'(value)));
  endtask

  task automatic set_triangle(longint ax, longint ay, longint bx, longint by,
                              longint cx, longint cy);
    write_reg(tbs_pkg::RegAX, ax);
    write_reg(tbs_pkg::RegAY, ay);
    write_reg(tbs_pkg::RegBX, bx);
    write_reg(tbs_pkg::RegBY, by);
    write_reg(tbs_pkg::RegCX, cx);
    write_reg(tbs_pkg::RegCY, cy);
    cfg_write <= 1'b0;
  endtask

  // Valid stays high after the item is taken so the next item can follow
  // directly; a gap or a drain drops it.
  task automatic send_pixel(int px, int py);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x <= 9'(px);
    pixel_y <= 8'(py);
    shade_queue.push_back(shade_pixel(px, py));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Waits for the pipe to empty; the extra cycles cover the full latency.
  task automatic drain;
    in_valid <= 1'b0;
    while (shade_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed;
    set_triangle(10, 10, 300, 20, 100, 230);
    send_pixel(10, 10);
    send_pixel(300, 20);
    send_pixel(100, 230);
    send_pixel(120, 80);
    send_pixel(0, 0);
    send_pixel(319, 239);
    send_pixel(320, 100);
    send_pixel(511, 255);
    send_pixel(0, 255);
    send_pixel(511, 0);
    drain();
    // Degenerate: all three vertices on one line.
    set_triangle(0, 0, 50, 50, 100, 100);
    send_pixel(25, 25);
    send_pixel(60, 60);
    drain();
    // Extreme coordinates, reversed winding.
    set_triangle(-1024, -1024, -1024, 1023, 1023, -1024);
    send_pixel(0, 0);
    send_pixel(319, 239);
    send_pixel(200, 200);
    drain();
    set_triangle(1023, 1023, -1024, 1023, 1023, -1024);
    send_pixel(319, 239);
    send_pixel(5, 7);
    drain();
    // An index past the last register is ignored.
    write_reg(3'd6, 11'h155);
    write_reg(3'd7, 11'h2AA);
    cfg_write <= 1'b0;
    send_pixel(160, 120);
    drain();
  endtask

  task automatic test_random_triangles;
    int k, n;
    for (k = 0; k < 8; k++) begin
      set_triangle($urandom_range(0, 340) - 10, $urandom_range(0, 260) - 10,
                   $urandom_range(0, 340) - 10, $urandom_range(0, 260) - 10,
                   $urandom_range(0, 340) - 10, $urandom_range(0, 260) - 10);
      for (n = 0; n < 55; n++) begin
        if ($urandom_range(0, 9) == 0) send_pixel($urandom_range(0, 511), $urandom_range(0, 255));
        else send_pixel($urandom_range(0, Cols - 1), $urandom_range(0, Rows - 1));
      end
      drain();
    end
  endtask

  task automatic test_raster_scan;
    int x, y;
    set_triangle(20, 5, 60, 30, 10, 40);
    for (y = 0; y < 44; y += 2)
      for (x = 0; x < 64; x += 3) send_pixel(x, y);
    drain();
    calm = 1'b1;
    set_triangle(0, 0, 319, 0, 0, 239);
    for (x = 0; x < 150; x++) send_pixel($urandom_range(0, Cols - 1), $urandom_range(0, Rows - 1));
    drain();
  endtask

  initial begin
    foreach (vert[i]) vert[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_triangles();
    test_raster_scan();
    $display("Shaded %0d pixels, %0d covered, over directed, random and raster triangles.",
             shaded, hits);
    if (errors == 0) $display("tb_triangle_barycentric_shader_top: clean");
    else $display("tb_triangle_barycentric_shader_top: errors");
    $finish;
  end

endmodule

@@ files.f @@
sv/tbs_pkg.sv
sv/tbs_setup.sv
sv/tbs_div_cell.sv
sv/tbs_shade.sv
sv/triangle_barycentric_shader_top.sv
sv/tbs_checker.sv
bench/tb_triangle_barycentric_shader_top.sv
